@@ rtl/bsu_pkg.sv @@
package bsu_pkg;

  // Number of values in one set; must be a power of two from 2 to 64.
  localparam int SET_SIZE    = 16;
  localparam int IDX_W       = $clog2(SET_SIZE);
  // Holds a stage exponent from 0 up to IDX_W.
  localparam int STG_W       = $clog2(IDX_W + 1);
  // Bit-select width for an index vector of IDX_W bits.
  localparam int TB_W        = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int VALUE_W     = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One accepted value on its way from the front end to the sort engine.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      dir;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } back_state_t;

endpackage

@@ rtl/bsu_front.sv @@
module bsu_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [bsu_pkg::VALUE_W-1:0]  in_element_value,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  bsu_pkg::q_status_t                  q_status,
  output logic                                busy,
  output logic                                push,
  output bsu_pkg::entry_t                     push_entry
);

  logic                       sort_ascending_r;
  logic [bsu_pkg::IDX_W-1:0]  loaded_count_r;
  logic [bsu_pkg::IDX_W-1:0]  loaded_count_nxt;
  logic                       is_last;

  // Stall the sender while the queue has no room
  assign busy = q_status.full;
  assign push = start && !busy;

  // Tag the value that completes a set, with the direction in force now
  assign is_last = (loaded_count_r == bsu_pkg::IDX_W'(bsu_pkg::SET_SIZE - 1));

  always_comb begin
    push_entry.value = in_element_value;
    push_entry.last  = is_last;
    push_entry.dir   = sort_ascending_r;
  end

  // Advance the fill count per transaction and wrap at the set size
  always_comb begin
    loaded_count_nxt = loaded_count_r;
    if (push) begin
      loaded_count_nxt = is_last ? '0 : loaded_count_r + bsu_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_count_r   <= '0;
      sort_ascending_r <= 1'b1;
    end else begin
      loaded_count_r <= loaded_count_nxt;
      if (cfg_wr_en) begin
        sort_ascending_r <= cfg_wr_data;
      end
    end
  end

endmodule

@@ rtl/bsu_queue.sv @@
module bsu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bsu_pkg::entry_t     push_entry,
  input  logic                pop,
  output bsu_pkg::entry_t     head,
  output bsu_pkg::q_status_t  status
);

  bsu_pkg::entry_t             slots_r [bsu_pkg::QUEUE_DEPTH];
  logic [bsu_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [bsu_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [bsu_pkg::QCNT_W-1:0]  count_r;
  logic                        do_push;
  logic                        do_pop;

  assign status.full  = (count_r == bsu_pkg::QCNT_W'(bsu_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots_r[rd_ptr_r];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + bsu_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + bsu_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + bsu_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - bsu_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/bsu_back.sv @@
module bsu_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bsu_pkg::entry_t                     head,
  input  bsu_pkg::q_status_t                  q_status,
  output logic                                pop,
  output logic                                out_strobe,
  output logic signed [bsu_pkg::VALUE_W-1:0]  out_sorted_value,
  output logic                                out_last_of_run
);

  bsu_pkg::back_state_t               state_r, state_nxt;
  logic signed [bsu_pkg::VALUE_W-1:0] cells_r    [bsu_pkg::SET_SIZE];
  logic signed [bsu_pkg::VALUE_W-1:0] cells_nxt  [bsu_pkg::SET_SIZE];
  logic signed [bsu_pkg::VALUE_W-1:0] stage_out  [bsu_pkg::SET_SIZE];
  logic [bsu_pkg::STG_W-1:0]          blk_r, blk_nxt;
  logic [bsu_pkg::STG_W-1:0]          dist_r, dist_nxt;
  logic [bsu_pkg::IDX_W-1:0]          emit_cnt_r, emit_cnt_nxt;
  logic                               dir_r, dir_nxt;
  logic                               strobe_r, strobe_nxt;
  logic signed [bsu_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic                               last_r, last_nxt;

  assign out_strobe       = strobe_r;
  assign out_sorted_value = value_r;
  assign out_last_of_run  = last_r;

  // One compare-exchange stage across the whole row: block size 2^blk, distance 2^dist
  always_comb begin
    logic [bsu_pkg::IDX_W-1:0]          pos;
    logic [bsu_pkg::IDX_W-1:0]          mate;
    logic                               lower;
    logic                               asc;
    logic                               gt;
    logic signed [bsu_pkg::VALUE_W-1:0] own;
    logic signed [bsu_pkg::VALUE_W-1:0] other;
    for (int i = 0; i < bsu_pkg::SET_SIZE; i++) begin
      pos   = bsu_pkg::IDX_W'(i);
      mate  = pos ^ (bsu_pkg::IDX_W'(1) << dist_r);
      lower = !pos[dist_r[bsu_pkg::TB_W-1:0]];
      // Final merge follows the register; inner blocks alternate up and down
      asc   = (blk_r == bsu_pkg::STG_W'(bsu_pkg::IDX_W)) ? dir_r
                                                         : !pos[blk_r[bsu_pkg::TB_W-1:0]];
      own   = cells_r[i];
      other = cells_r[mate];
      gt    = lower ? (own > other) : (other > own);
      stage_out[i] = (asc == gt) ? other : own;
    end
  end

  // Sequence load, sort and emit
  always_comb begin
    state_nxt    = state_r;
    cells_nxt    = cells_r;
    blk_nxt      = blk_r;
    dist_nxt     = dist_r;
    emit_cnt_nxt = emit_cnt_r;
    dir_nxt      = dir_r;
    strobe_nxt   = 1'b0;
    value_nxt    = value_r;
    last_nxt     = last_r;
    pop          = 1'b0;
    case (state_r)
      bsu_pkg::ST_LOAD: begin
        // Shift each dequeued value in at the top of the row
        if (!q_status.empty) begin
          pop = 1'b1;
          for (int i = 0; i < bsu_pkg::SET_SIZE - 1; i++) begin
            cells_nxt[i] = cells_r[i+1];
          end
          cells_nxt[bsu_pkg::SET_SIZE-1] = head.value;
          if (head.last) begin
            dir_nxt   = head.dir;
            blk_nxt   = bsu_pkg::STG_W'(1);
            dist_nxt  = '0;
            state_nxt = bsu_pkg::ST_SORT;
          end
        end
      end
      bsu_pkg::ST_SORT: begin
        cells_nxt = stage_out;
        if (dist_r == '0) begin
          if (blk_r == bsu_pkg::STG_W'(bsu_pkg::IDX_W)) begin
            emit_cnt_nxt = '0;
            state_nxt    = bsu_pkg::ST_EMIT;
          end else begin
            blk_nxt  = blk_r + bsu_pkg::STG_W'(1);
            dist_nxt = blk_r;
          end
        end else begin
          dist_nxt = dist_r - bsu_pkg::STG_W'(1);
        end
      end
      bsu_pkg::ST_EMIT: begin
        // Drive the bottom cell out and shift the row down
        strobe_nxt = 1'b1;
        value_nxt  = cells_r[0];
        last_nxt   = (emit_cnt_r == bsu_pkg::IDX_W'(bsu_pkg::SET_SIZE - 1));
        for (int i = 0; i < bsu_pkg::SET_SIZE - 1; i++) begin
          cells_nxt[i] = cells_r[i+1];
        end
        emit_cnt_nxt = emit_cnt_r + bsu_pkg::IDX_W'(1);
        if (last_nxt) begin
          state_nxt = bsu_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = bsu_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bsu_pkg::ST_LOAD;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Hold payload and sequencing registers without reset
  always_ff @(posedge clk) begin
    cells_r    <= cells_nxt;
    blk_r      <= blk_nxt;
    dist_r     <= dist_nxt;
    emit_cnt_r <= emit_cnt_nxt;
    dir_r      <= dir_nxt;
    value_r    <= value_nxt;
    last_r     <= last_nxt;
  end

endmodule

@@ rtl/bitonic_sorter_unit.sv @@
// Bitonic sorter unit.
// Input: a transaction is taken when start is high and busy is low; each
// carries one signed 32-bit value. Every SET_SIZE values form one set.
// Configuration: cfg_wr_en writes cfg_wr_data into the direction bit
// (1 smallest first, 0 largest first); the bit is tagged onto the value
// that completes a set. Reset sets it to ascending.
// Output: out_strobe marks each of the SET_SIZE sorted values for one cycle;
// out_last_of_run flags the final value of the set. The receiver cannot
// stall, so results simply stream out one per cycle.
// Timing: values pass through a four-entry queue into a row of compare
// cells, loading one per cycle while the queue holds a value. The network
// then runs one stage per cycle, log2(N)*(log2(N)+1)/2 stages (10 for
// N = 16), and then shifts the sorted values out. The queue keeps taking
// values of the next set while the row is sorting or emitting; busy rises
// once the queue fills.
// Reset: rst_n (synchronous, active low) empties the queue, clears the fill
// count and returns the row to loading.
module bitonic_sorter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [bsu_pkg::VALUE_W-1:0]  in_element_value,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  output logic                                out_strobe,
  output logic signed [bsu_pkg::VALUE_W-1:0]  out_sorted_value,
  output logic                                out_last_of_run
);

  bsu_pkg::q_status_t q_status;
  bsu_pkg::entry_t    push_entry;
  bsu_pkg::entry_t    head;
  logic               push;
  logic               pop;

  bsu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_element_value (in_element_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_status         (q_status),
    .busy             (busy),
    .push             (push),
    .push_entry       (push_entry)
  );

  bsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  bsu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_status         (q_status),
    .pop              (pop),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

@@ test/bitonic_sorter_unit_test.sv @@
module bitonic_sorter_unit_test;

  localparam int VALUE_W        = bsu_pkg::VALUE_W;
  localparam int SET_SIZE       = bsu_pkg::SET_SIZE;
  localparam int RANDOM_ITEMS   = 400;
  // Long enough for a full sort and emission after the last value is taken.
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum int {
    KIND_FULL,
    KIND_NARROW,
    KIND_EDGES,
    KIND_SAME,
    KIND_RISING,
    KIND_FALLING
  } fill_kind_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } sorted_item_t;

  logic                      clk;
  logic                      rst_n            = 1'b0;
  logic                      start            = 1'b0;
  logic                      busy;
  logic signed [VALUE_W-1:0] in_element_value = '0;
  logic                      cfg_wr_en        = 1'b0;
  logic                      cfg_wr_data      = 1'b0;
  logic                      out_strobe;
  logic signed [VALUE_W-1:0] out_sorted_value;
  logic                      out_last_of_run;

  logic signed [VALUE_W-1:0] pending_values [$];
  sorted_item_t              expected_sorted [$];

  // Shadow of the set being collected and of the direction bit
  logic signed [VALUE_W-1:0] set_values [SET_SIZE];
  int                        set_fill;
  logic                      ascending_setting;

  bit                        idling_on;
  int                        idle_left;
  int                        mismatch_count;
  int                        result_index;
  int                        stall_cycles;
  int                        items_queued;

  bitonic_sorter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_element_value (in_element_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Sort the completed set and queue it in the order the direction bit asks
  task automatic finish_set();
    logic signed [VALUE_W-1:0] ordered [SET_SIZE];
    logic signed [VALUE_W-1:0] held;
    int                        j;
    sorted_item_t              item;
    ordered = set_values;
    for (int i = 1; i < SET_SIZE; i++) begin
      held = ordered[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > held) begin
        ordered[j+1] = ordered[j];
        j--;
      end
      ordered[j+1] = held;
    end
    for (int k = 0; k < SET_SIZE; k++) begin
      item.value = ascending_setting ? ordered[k] : ordered[SET_SIZE-1-k];
      item.last  = (k == SET_SIZE - 1);
      expected_sorted.push_back(item);
    end
  endtask

  // Collect one accepted value; a full set produces its expected results
  task automatic collect_value(input logic signed [VALUE_W-1:0] value);
    set_values[set_fill] = value;
    set_fill++;
    if (set_fill == SET_SIZE) begin
      finish_set();
      set_fill = 0;
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(
    input fill_kind_t kind, input int idx, input logic signed [VALUE_W-1:0] anchor);
    case (kind)
      KIND_NARROW:  return anchor + $urandom_range(0, 3);
      KIND_SAME:    return anchor;
      KIND_RISING:  return anchor + idx * 7;
      KIND_FALLING: return anchor - idx * 7;
      KIND_EDGES: begin
        case ($urandom_range(0, 4))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          3:       return -1;
          default: return $urandom;
        endcase
      end
      default:      return $urandom;
    endcase
  endfunction

  task automatic queue_values(input fill_kind_t kind, input int count);
    logic signed [VALUE_W-1:0] anchor;
    anchor = $urandom;
    for (int i = 0; i < count; i++) begin
      pending_values.push_back(pick_value(kind, i, anchor));
    end
    items_queued += count;
  endtask

  task automatic queue_random_set_part(input int count);
    int r;
    r = $urandom_range(0, 9);
    queue_values((r > 5) ? KIND_FULL : fill_kind_t'(r), count);
  endtask

  // Wait until every queued value is taken and every expected result is out
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_values.size() != 0 || start || expected_sorted.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic ascending);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ascending;
    ascending_setting = ascending;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Driver: hold start until the transaction is taken, insert random gaps
  always @(posedge clk) begin
    bit taken;
    taken = 1'b0;
    if (!rst_n) begin
      start            <= 1'b0;
      in_element_value <= '0;
      idle_left        = 0;
    end else begin
      if (start && !busy) begin
        collect_value(in_element_value);
        taken = 1'b1;
      end
      if (!start || taken) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_values.size() != 0) begin
          start            <= 1'b1;
          in_element_value <= pending_values.pop_front();
          if (idling_on && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 3);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expected one
  always @(posedge clk) begin
    sorted_item_t want;
    if (rst_n && out_strobe) begin
      if (expected_sorted.size() == 0) begin
        report_mismatch($sformatf("result %0d with none expected: value %0d last %0b",
                                  result_index, out_sorted_value, out_last_of_run));
      end else begin
        want = expected_sorted.pop_front();
        if (out_sorted_value !== want.value)
          report_mismatch($sformatf("result %0d: sorted_value %0d, want %0d",
                                    result_index, out_sorted_value, want.value));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("result %0d: last_of_run %0b, want %0b",
                                    result_index, out_last_of_run, want.last));
      end
      result_index++;
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int partial;
    ascending_setting = 1'b1;
    set_fill          = 0;
    idling_on         = 1'b1;
    idle_left         = 0;
    mismatch_count    = 0;
    result_index      = 0;
    items_queued      = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes and duplicates under the reset direction
    pending_values = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN + 1, VAL_MAX - 1,
                       32'sh5555_5555, 32'shAAAA_AAAA, 5, 5, 5, -5, 100, VAL_MIN, VAL_MAX};
    wait_idle();

    // Flip direction partway through a set; only the setting at completion counts
    write_direction(1'b0);
    pending_values = '{3, VAL_MAX, -7, VAL_MIN, 3, 0};
    wait_idle();
    write_direction(1'b1);
    pending_values = '{9, -9, 1, 2, VAL_MAX, VAL_MIN, 42, -42, 3, 0};
    wait_idle();

    // Random phases, each under its own direction setting, some flipping it partway through a set
    for (int phase = 0; items_queued < RANDOM_ITEMS; phase++) begin
      if (items_queued >= RANDOM_ITEMS * 4 / 5) idling_on = 1'b0;
      write_direction((phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      repeat ($urandom_range(2, 4)) queue_random_set_part(SET_SIZE);
      if ($urandom_range(0, 2) == 0) begin
        partial = $urandom_range(1, SET_SIZE - 1);
        queue_random_set_part(partial);
        wait_idle();
        write_direction(~ascending_setting);
        queue_random_set_part(SET_SIZE - partial);
      end
      wait_idle();
    end

    if (expected_sorted.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_sorted.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bsu_pkg.sv
rtl/bsu_front.sv
rtl/bsu_queue.sv
rtl/bsu_back.sv
rtl/bitonic_sorter_unit.sv
test/bitonic_sorter_unit_test.sv
